// File: rtl/nearest_palette_halfbrite_match_defines.svh
// ----------------------------------------------------------------------------
// nearest_palette_halfbrite_match_defines.svh
// assertion macros for the palette search rtl
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_HALFBRITE_MATCH_DEFINES_SVH
`define NEAREST_PALETTE_HALFBRITE_MATCH_DEFINES_SVH

// antecedent this cycle, consequent on the next edge
`define NPHM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nphm check failed");

// signal holds its value on the edge after the condition
`define NPHM_ASSERT_HOLD(name, cond, sig) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("nphm hold check failed");

`endif

// File: rtl/nphm_pkg.sv
// ----------------------------------------------------------------------------
// nphm_pkg
// shared types and codes for the half-brite palette search
// ----------------------------------------------------------------------------
package nphm_pkg;

    // width of the palette slot and result index fields
    localparam int INDEX_BITS = 5;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_PIXEL = 1'b1
    } opcode_t;

    // control that travels with each word down the cell chain
    typedef struct packed
    {
        logic valid;
        logic pixel;
    } ctrl_t;

endpackage

// File: rtl/nphm_cell.sv
// ----------------------------------------------------------------------------
// nphm_cell
// one palette entry: holds the colour, scores passing pixels against its
// full and halved colour and forwards the running best
// ----------------------------------------------------------------------------
module nphm_cell #(
    parameter int COMPONENT_BITS = 5,
    parameter int IDX_W          = 5,
    parameter int DIST_W         = 12,
    parameter int CELL_ID        = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  nphm_pkg::ctrl_t                ctrl_in,
    input  logic [nphm_pkg::INDEX_BITS-1:0] entry_in,
    input  logic [COMPONENT_BITS-1:0]      red_in,
    input  logic [COMPONENT_BITS-1:0]      green_in,
    input  logic [COMPONENT_BITS-1:0]      blue_in,
    input  logic [IDX_W-1:0]               best_in,
    input  logic                           half_in,
    input  logic [DIST_W-1:0]              dist_in,
    output nphm_pkg::ctrl_t                ctrl_out,
    output logic [nphm_pkg::INDEX_BITS-1:0] entry_out,
    output logic [COMPONENT_BITS-1:0]      red_out,
    output logic [COMPONENT_BITS-1:0]      green_out,
    output logic [COMPONENT_BITS-1:0]      blue_out,
    output logic [IDX_W-1:0]               best_out,
    output logic                           half_out,
    output logic [DIST_W-1:0]              dist_out
);
    import nphm_pkg::*;

    localparam int C = COMPONENT_BITS;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

    // stored palette colour
    logic [C-1:0]        pal_r_reg;
    logic [C-1:0]        pal_g_reg;
    logic [C-1:0]        pal_b_reg;

    // word handed to the next cell
    ctrl_t               ctrl_reg;
    logic [INDEX_BITS-1:0] entry_reg;
    logic [C-1:0]        red_reg;
    logic [C-1:0]        green_reg;
    logic [C-1:0]        blue_reg;
    logic [IDX_W-1:0]    best_reg;
    logic                half_reg;
    logic [DIST_W-1:0]   dist_reg;

    logic                load_hit;
    logic [C-1:0]        hr;
    logic [C-1:0]        hg;
    logic [C-1:0]        hb;
    logic [C-1:0]        ad_fr;
    logic [C-1:0]        ad_fg;
    logic [C-1:0]        ad_fb;
    logic [C-1:0]        ad_hr;
    logic [C-1:0]        ad_hg;
    logic [C-1:0]        ad_hb;
    logic [2*C-1:0]      sq_fr;
    logic [2*C-1:0]      sq_fg;
    logic [2*C-1:0]      sq_fb;
    logic [2*C-1:0]      sq_hr;
    logic [2*C-1:0]      sq_hg;
    logic [2*C-1:0]      sq_hb;
    logic [DIST_W-1:0]   dist_full;
    logic [DIST_W-1:0]   dist_half;
    logic                use_half;
    logic [DIST_W-1:0]   cand_dist;
    logic                take;

    assign load_hit = ctrl_in.valid && (ctrl_in.pixel == OP_LOAD)
                      && (int'(entry_in) == CELL_ID);

    assign hr = pal_r_reg >> 1;
    assign hg = pal_g_reg >> 1;
    assign hb = pal_b_reg >> 1;

    assign ad_fr = (red_in   >= pal_r_reg) ? red_in   - pal_r_reg : pal_r_reg - red_in;
    assign ad_fg = (green_in >= pal_g_reg) ? green_in - pal_g_reg : pal_g_reg - green_in;
    assign ad_fb = (blue_in  >= pal_b_reg) ? blue_in  - pal_b_reg : pal_b_reg - blue_in;
    assign ad_hr = (red_in   >= hr) ? red_in   - hr : hr - red_in;
    assign ad_hg = (green_in >= hg) ? green_in - hg : hg - green_in;
    assign ad_hb = (blue_in  >= hb) ? blue_in  - hb : hb - blue_in;

    assign sq_fr = {{C{1'b0}}, ad_fr} * {{C{1'b0}}, ad_fr};
    assign sq_fg = {{C{1'b0}}, ad_fg} * {{C{1'b0}}, ad_fg};
    assign sq_fb = {{C{1'b0}}, ad_fb} * {{C{1'b0}}, ad_fb};
    assign sq_hr = {{C{1'b0}}, ad_hr} * {{C{1'b0}}, ad_hr};
    assign sq_hg = {{C{1'b0}}, ad_hg} * {{C{1'b0}}, ad_hg};
    assign sq_hb = {{C{1'b0}}, ad_hb} * {{C{1'b0}}, ad_hb};

    assign dist_full = DIST_W'(sq_fr) + DIST_W'(sq_fg) + DIST_W'(sq_fb);
    assign dist_half = DIST_W'(sq_hr) + DIST_W'(sq_hg) + DIST_W'(sq_hb);

    // full colour is checked first, so half only wins when strictly closer
    assign use_half  = dist_half < dist_full;
    assign cand_dist = use_half ? dist_half : dist_full;
    // entry 0 always seeds the running best
    assign take      = (CELL_ID == 0) || (cand_dist < dist_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_r_reg <= '0;
            pal_g_reg <= '0;
            pal_b_reg <= '0;
            ctrl_reg  <= '0;
        end
        else if (adv)
        begin
            ctrl_reg <= ctrl_in;
            if (load_hit)
            begin
                pal_r_reg <= red_in;
                pal_g_reg <= green_in;
                pal_b_reg <= blue_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            entry_reg <= entry_in;
            red_reg   <= red_in;
            green_reg <= green_in;
            blue_reg  <= blue_in;
            best_reg  <= take ? MY_IDX : best_in;
            half_reg  <= take ? use_half : half_in;
            dist_reg  <= take ? cand_dist : dist_in;
        end
    end

    assign ctrl_out  = ctrl_reg;
    assign entry_out = entry_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign best_out  = best_reg;
    assign half_out  = half_reg;
    assign dist_out  = dist_reg;

endmodule

// File: rtl/nearest_palette_halfbrite_match.sv
// ----------------------------------------------------------------------------
// nearest_palette_halfbrite_match
// latency: an accepted pixel word passes through every cell of the chain,
// one register per cell, before its result appears
// throughput: one word (load or pixel) per cycle while the result side flows
// reset: every palette entry reads as black, the chain is empty
// ----------------------------------------------------------------------------
`include "nearest_palette_halfbrite_match_defines.svh"

module nearest_palette_halfbrite_match #(
    parameter int PALETTE_ENTRIES = 32,
    parameter int COMPONENT_BITS  = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // word side
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic                            opcode,
    input  logic [nphm_pkg::INDEX_BITS-1:0] entry_index,
    input  logic [COMPONENT_BITS-1:0]       red,
    input  logic [COMPONENT_BITS-1:0]       green,
    input  logic [COMPONENT_BITS-1:0]       blue,
    // result side
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [nphm_pkg::INDEX_BITS-1:0] best_index,
    output logic                            half_brite
);
    import nphm_pkg::*;

    localparam int N      = PALETTE_ENTRIES;
    localparam int IDX_W  = $clog2(PALETTE_ENTRIES);
    // three squares of a component difference
    localparam int DIST_W = 2 * COMPONENT_BITS + 2;

    // stage k feeds cell k; stage N is the tail of the chain
    ctrl_t                   st_ctrl  [N+1];
    logic [INDEX_BITS-1:0]   st_entry [N+1];
    logic [COMPONENT_BITS-1:0] st_r   [N+1];
    logic [COMPONENT_BITS-1:0] st_g   [N+1];
    logic [COMPONENT_BITS-1:0] st_b   [N+1];
    logic [IDX_W-1:0]        st_best  [N+1];
    logic                    st_half  [N+1];
    logic [DIST_W-1:0]       st_dist  [N+1];

    // whole chain moves together; it only halts when a finished result waits
    logic adv;

    assign adv        = !(result_valid && result_stall);
    assign item_stall = !adv;

    // head of the chain straight from the word side; running best is seeded
    // by cell 0, so the seed values here are never chosen
    assign st_ctrl[0]  = ctrl_t'{valid: item_valid, pixel: opcode};
    assign st_entry[0] = entry_index;
    assign st_r[0]     = red;
    assign st_g[0]     = green;
    assign st_b[0]     = blue;
    assign st_best[0]  = '0;
    assign st_half[0]  = 1'b0;
    assign st_dist[0]  = '0;

    // one cell per palette entry; loads travel with pixels so every pixel
    // sees the palette as it was when the pixel was accepted
    for (genvar k = 0; k < N; k++)
    begin : g_cell
        nphm_cell #(
            .COMPONENT_BITS (COMPONENT_BITS),
            .IDX_W          (IDX_W),
            .DIST_W         (DIST_W),
            .CELL_ID        (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .ctrl_in   (st_ctrl[k]),
            .entry_in  (st_entry[k]),
            .red_in    (st_r[k]),
            .green_in  (st_g[k]),
            .blue_in   (st_b[k]),
            .best_in   (st_best[k]),
            .half_in   (st_half[k]),
            .dist_in   (st_dist[k]),
            .ctrl_out  (st_ctrl[k+1]),
            .entry_out (st_entry[k+1]),
            .red_out   (st_r[k+1]),
            .green_out (st_g[k+1]),
            .blue_out  (st_b[k+1]),
            .best_out  (st_best[k+1]),
            .half_out  (st_half[k+1]),
            .dist_out  (st_dist[k+1])
        );
    end

    // the last cell's registers are the output register; load words drain
    // out of the tail without a result
    assign result_valid = st_ctrl[N].valid && (st_ctrl[N].pixel == OP_PIXEL);
    assign best_index   = INDEX_BITS'(st_best[N]);
    assign half_brite   = st_half[N];

    // accepted pixel enters the first cell as a pixel
    `NPHM_ASSERT_NEXT(a_pixel_enters, item_valid && !item_stall && opcode == OP_PIXEL,
        st_ctrl[1].valid && st_ctrl[1].pixel == OP_PIXEL)
    // accepted load enters the first cell as a load
    `NPHM_ASSERT_NEXT(a_load_enters, item_valid && !item_stall && opcode == OP_LOAD,
        st_ctrl[1].valid && st_ctrl[1].pixel == OP_LOAD)
    // idle input cycle leaves a bubble in the first cell
    `NPHM_ASSERT_NEXT(a_bubble_enters, !item_valid && adv, !st_ctrl[1].valid)
    // a frozen chain keeps its running best
    `NPHM_ASSERT_HOLD(a_chain_frozen, item_stall, st_dist[1])

endmodule
